/* design/udiv64_pkg.sv */
// udiv64_pkg: widths, pipeline shape and the per-stage state word of the
// 64 by 32 unsigned divider. no dependencies.
package udiv64_pkg;

  localparam int DIVIDEND_W      = 64;
  localparam int DIVISOR_W       = 32;
  // quotient bits resolved in each pipeline stage
  localparam int STEPS_PER_STAGE = 2;
  localparam int STAGES          = DIVIDEND_W / STEPS_PER_STAGE;

  // work holds unconsumed dividend bits at the top, quotient bits shift in at the bottom
  typedef struct packed {
    logic [DIVIDEND_W-1:0] work;
    logic [DIVISOR_W-1:0]  partial;
    logic [DIVISOR_W-1:0]  divisor;
    logic                  div_zero;
  } div_state_t;

endpackage

/* design/udiv64_stage.sv */
// udiv64_stage: one register stage of the divider pipeline, resolving
// STEPS_PER_STAGE quotient bits by restoring shift-and-subtract.
// depends on udiv64_pkg.
module udiv64_stage import udiv64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       in_valid,
  input  div_state_t in_state,
  output logic       out_valid,
  output div_state_t out_state
);

  div_state_t state_next;

  always_comb begin
    div_state_t         s;
    logic [DIVISOR_W:0] rem_wide;
    s = in_state;
    rem_wide = '0;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      rem_wide = {s.partial, s.work[DIVIDEND_W-1]};
      s.work   = s.work << 1;
      if (rem_wide >= {1'b0, s.divisor}) begin
        rem_wide  = rem_wide - {1'b0, s.divisor};
        s.work[0] = 1'b1;
      end
      s.partial = rem_wide[DIVISOR_W-1:0];
    end
    state_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state <= state_next;
    end
  end

endmodule

/* design/unsigned_divide_64_by_32.sv */
// Unsigned 64 by 32 divider, fully pipelined: a new beat can be taken every
// cycle while the output is not stalled, and each beat passes through all
// STAGES register stages on its way to the output. There is one
// register stage per two quotient bits of restoring division. A stall on
// the output freezes the whole pipeline and is passed straight back as
// in_stall, so nothing is lost or repeated. A zero divisor gives a quotient of
// all ones, a remainder of zero and divide_by_zero set.
// top level; depends on udiv64_pkg and udiv64_stage.
module unsigned_divide_64_by_32 import udiv64_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder,
  output logic                  divide_by_zero
);

  logic       advance;
  logic       stage_valid [STAGES];
  div_state_t stage_state [STAGES];
  div_state_t entry_state;
  div_state_t last_state;

  // the whole pipe holds while a finished beat waits on the output
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_comb begin
    entry_state.work     = dividend;
    entry_state.partial  = '0;
    entry_state.divisor  = divisor;
    entry_state.div_zero = (divisor == '0);
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      udiv64_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_state  (entry_state),
        .out_valid (stage_valid[i]),
        .out_state (stage_state[i])
      );
    end else begin : g_next
      udiv64_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .in_valid  (stage_valid[i-1]),
        .in_state  (stage_state[i-1]),
        .out_valid (stage_valid[i]),
        .out_state (stage_state[i])
      );
    end
  end

  assign last_state     = stage_state[STAGES-1];
  assign out_valid      = stage_valid[STAGES-1];
  assign divide_by_zero = last_state.div_zero;
  assign quotient       = last_state.div_zero ? '1 : last_state.work;
  assign remainder      = last_state.div_zero ? '0 : last_state.partial;

  // a finished division always leaves a remainder below its divisor
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_state.div_zero |-> last_state.partial < last_state.divisor)
    else $error("remainder not below divisor");

  // the zero flag must agree with the divisor carried down the pipe
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> divide_by_zero == (last_state.divisor == '0))
    else $error("divide_by_zero disagrees with carried divisor");

  // a held output beat freezes the pipe, so the input side must be stalled too
  a_hold_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output beat held");

  // a beat taken at the input must show up as valid in the first stage
  a_entry_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> stage_valid[0] || !$past(advance))
    else $error("accepted beat dropped at pipe entry");

endmodule
